@@ hdl/cmpu_pkg.sv @@
// ---------------------------------------------------------------------------
// cmpu_pkg
// Types and constants used by the clone memory paging unit: command
// codes, register indexes, port decode masks.
// ---------------------------------------------------------------------------
package cmpu_pkg;

  // bus event codes carried by the command field
  typedef enum logic [2:0] {
    CMD_PORT_WRITE = 3'd0,
    CMD_FETCH      = 3'd1,
    CMD_ACCESS     = 3'd2,
    CMD_MAGIC_NMI  = 3'd3,
    CMD_RESET      = 3'd4
  } command_t;

  // configuration register indexes
  localparam logic CFG_MACHINE_MODEL = 1'b0;
  localparam logic CFG_SERVICE_ROM   = 1'b1;

  // machine model codes
  localparam logic MODEL_1024K = 1'b0;
  localparam logic MODEL_256K  = 1'b1;

  // port decode, 1024K model
  localparam logic [15:0] MAIN_MASK_1024  = 16'h8002;
  localparam logic [15:0] HIGH_MASK_1024  = 16'hF002;
  localparam logic [15:0] HIGH_MATCH_1024 = 16'hD000;

  // port decode, 256K model
  localparam logic [15:0] PORT_MASK_256   = 16'hC023;
  localparam logic [15:0] MAIN_MATCH_256  = 16'h4021;
  localparam logic [15:0] EXTRA_MATCH_256 = 16'h0021;

  // disk rom entry trap window, upper address byte
  localparam logic [7:0] TRAP_ENTRY_HI = 8'h3D;

  // fixed ram pages of the middle windows
  localparam logic [5:0] PAGE_WIN1 = 6'd5;
  localparam logic [5:0] PAGE_WIN2 = 6'd2;

  // screen pages
  localparam logic [2:0] SCREEN_NORMAL = 3'd5;
  localparam logic [2:0] SCREEN_SHADOW = 3'd7;

  // border colour after reset
  localparam logic [2:0] BORDER_RESET = 3'd7;

  // latches and flags of the paging unit
  typedef struct packed {
    logic [7:0] main_latch;
    logic [7:0] extra_latch;
    logic       high_page;
    logic       lock;
    logic       nmi_pending;
    logic       disk_active;
    logic [2:0] border;
    logic       speaker;
  } paging_state_t;

endpackage

@@ hdl/cmpu_cmd_if.sv @@
// ---------------------------------------------------------------------------
// cmpu_cmd_if
// Bus event channel into the paging unit: command, address and data word.
// ---------------------------------------------------------------------------
interface cmpu_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [15:0] address;
  logic [7:0]  data;

  modport source (output valid, command, address, data, input ready);
  modport sink   (input valid, command, address, data, output ready);
endinterface

@@ hdl/cmpu_rsp_if.sv @@
// ---------------------------------------------------------------------------
// cmpu_rsp_if
// Result channel out of the paging unit: mapping and status word.
// ---------------------------------------------------------------------------
interface cmpu_rsp_if;
  logic        valid;
  logic        ready;
  logic        target_is_ram;
  logic [5:0]  page;
  logic [13:0] offset;
  logic        writable;
  logic [2:0]  screen_page;
  logic        disk_rom_active;
  logic        paging_locked;
  logic [2:0]  border_color;
  logic        speaker_on;

  modport source (output valid, target_is_ram, page, offset, writable, screen_page,
                  disk_rom_active, paging_locked, border_color, speaker_on,
                  input ready);
  modport sink   (input valid, target_is_ram, page, offset, writable, screen_page,
                  disk_rom_active, paging_locked, border_color, speaker_on,
                  output ready);
endinterface

@@ hdl/cmpu_cfg_if.sv @@
// ---------------------------------------------------------------------------
// cmpu_cfg_if
// Configuration write channel: register index and write data.
// ---------------------------------------------------------------------------
interface cmpu_cfg_if;
  logic valid;
  logic ready;
  logic index;
  logic data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ hdl/clone_memory_paging_unit.sv @@
// ---------------------------------------------------------------------------
// clone_memory_paging_unit
// Paging unit of a 128K-style clone (1024K or 256K model): port latches,
// disk rom traps, and mapping of each address to a rom/ram page and offset.
// ---------------------------------------------------------------------------
//  channel  dir  contents
//  cfg      in   index, data (machine model, service rom present)
//  req      in   command, address, data
//  rsp      out  mapping (ram flag, page, offset, writable) and status
//
//  One word in, one word out; a new word is taken every cycle unless the result side stalls.
//  The latch update and the address decode sit
//  between the request handshake and the result register.
//  The request side stalls only while a result is held and rsp.ready is low.
//  rst clears the latches, flags, configuration and rsp.valid and sets the border to BORDER_RESET;
//  the cfg port is always ready.
module clone_memory_paging_unit
  import cmpu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  cmpu_cfg_if.sink   cfg,
  cmpu_cmd_if.sink   req,
  cmpu_rsp_if.source rsp
);

  logic          machine_model;
  logic          service_rom;
  paging_state_t st;
  paging_state_t st_next;
  logic          accept;
  command_t      cmd;
  logic          low_ram;
  logic [1:0]    rom_page;
  logic [5:0]    top_page;
  logic          map_ram;
  logic [5:0]    map_page;
  logic [13:0]   map_offset;
  logic          map_wr;

  assign cmd    = command_t'(req.command);
  assign accept = req.valid && req.ready;

  // configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      machine_model <= MODEL_1024K;
      service_rom   <= 1'b0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_MACHINE_MODEL: machine_model <= cfg.data;
        CFG_SERVICE_ROM:   service_rom   <= cfg.data;
        default:           ;
      endcase
    end
  end

  // latch and flag update for one word
  always_comb begin
    st_next = st;
    case (cmd)
      CMD_PORT_WRITE: begin
        if (!req.address[0]) begin
          st_next.border  = req.data[2:0];
          st_next.speaker = req.data[4];
        end
        if (machine_model == MODEL_1024K) begin
          if ((req.address & MAIN_MASK_1024) == 16'h0000 && req.address[0] && !st.lock) begin
            st_next.main_latch = req.data;
            st_next.lock       = req.data[5];
          end
          if ((req.address & HIGH_MASK_1024) == HIGH_MATCH_1024) begin
            st_next.high_page = req.data[0];
          end
        end else begin
          if ((req.address & PORT_MASK_256) == MAIN_MATCH_256 && !st.lock) begin
            st_next.main_latch = req.data;
            st_next.lock       = req.data[5];
          end
          if ((req.address & PORT_MASK_256) == EXTRA_MATCH_256) begin
            st_next.extra_latch = req.data;
          end
        end
      end
      CMD_FETCH: begin
        // disk rom entry and exit traps
        if (req.address[15:8] == TRAP_ENTRY_HI) begin
          if (st.main_latch[4] &&
              !(machine_model == MODEL_256K && st.extra_latch[0] && !st.nmi_pending)) begin
            st_next.disk_active = 1'b1;
          end
        end else if (req.address[15:14] != 2'b00) begin
          st_next.nmi_pending = 1'b0;
          st_next.disk_active = 1'b0;
        end
      end
      CMD_MAGIC_NMI: begin
        st_next.nmi_pending = 1'b1;
        if (machine_model == MODEL_256K) begin
          st_next.disk_active = 1'b1;
        end
      end
      CMD_RESET: begin
        st_next             = '0;
        st_next.border      = BORDER_RESET;
        st_next.disk_active = (machine_model == MODEL_1024K) && service_rom;
      end
      default: ;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '{main_latch: 8'h00, extra_latch: 8'h00, high_page: 1'b0, lock: 1'b0,
              nmi_pending: 1'b0, disk_active: 1'b0, border: BORDER_RESET,
              speaker: 1'b0};
    end else if (accept) begin
      st <= st_next;
    end
  end

  // rom page selection and top window page, from the updated latches
  always_comb begin
    low_ram = (machine_model == MODEL_256K) && st_next.extra_latch[0] && !st_next.nmi_pending;
    if (machine_model == MODEL_1024K) begin
      if (st_next.disk_active) begin
        rom_page = (service_rom && !st_next.main_latch[4]) ? 2'd2 : 2'd3;
      end else begin
        rom_page = {1'b0, st_next.main_latch[4]};
      end
      top_page = {st_next.high_page, st_next.main_latch[7:6], st_next.main_latch[2:0]};
    end else begin
      if (st_next.extra_latch[1]) begin
        rom_page = 2'd2;
      end else begin
        rom_page = {st_next.nmi_pending || st_next.disk_active, st_next.main_latch[4]};
      end
      top_page = {2'b00, st_next.extra_latch[4], st_next.main_latch[2:0]};
    end
  end

  // address decode for fetches and memory accesses
  always_comb begin
    map_ram    = 1'b0;
    map_page   = '0;
    map_offset = '0;
    map_wr     = 1'b0;
    if (cmd == CMD_FETCH || cmd == CMD_ACCESS) begin
      map_offset = req.address[13:0];
      case (req.address[15:14])
        2'd0: begin
          if (low_ram) begin
            map_ram = 1'b1;
            map_wr  = 1'b1;
          end else begin
            map_page = {4'b0000, rom_page};
          end
        end
        2'd1: begin
          map_ram  = 1'b1;
          map_page = PAGE_WIN1;
          map_wr   = 1'b1;
        end
        2'd2: begin
          map_ram  = 1'b1;
          map_page = PAGE_WIN2;
          map_wr   = 1'b1;
        end
        default: begin
          map_ram  = 1'b1;
          map_page = top_page;
          map_wr   = 1'b1;
        end
      endcase
    end
  end

  // result register
  assign req.ready = !rsp.valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (req.ready) begin
      rsp.valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.target_is_ram   <= map_ram;
      rsp.page            <= map_page;
      rsp.offset          <= map_offset;
      rsp.writable        <= map_wr;
      rsp.screen_page     <= st_next.main_latch[3] ? SCREEN_SHADOW : SCREEN_NORMAL;
      rsp.disk_rom_active <= st_next.disk_active;
      rsp.paging_locked   <= st_next.lock;
      rsp.border_color    <= st_next.border;
      rsp.speaker_on      <= st_next.speaker;
    end
  end

`ifndef SYNTHESIS
  // lock holds until a machine reset word
  a_lock_holds: assert property (@(posedge clk) disable iff (rst)
    (st.lock && !(accept && cmd == CMD_RESET)) |=> st.lock)
    else $error("paging lock dropped without machine reset");

  // port writes give no mapping
  a_port_no_map: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd == CMD_PORT_WRITE) |=>
      (!rsp.target_is_ram && rsp.page == 6'd0 && !rsp.writable && rsp.offset == 14'd0))
    else $error("mapping reported for a port write");

  // rom results carry a rom page and are never writable
  a_rom_page: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.target_is_ram) |-> (rsp.page < 6'd4 && !rsp.writable))
    else $error("rom result with bad page or write enable");

  // the result reflects the latch state taken with it
  a_rsp_status: assert property (@(posedge clk) disable iff (rst)
    accept |=> (rsp.paging_locked == st.lock && rsp.disk_rom_active == st.disk_active))
    else $error("result status differs from latch state");
`endif

endmodule
